>>> rtl/cmm_pkg.sv
package cmm_pkg;

    // field widths of the request and result items
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int ELEM_W  = 16;
    localparam int OUT_W   = 24;
    localparam int DIM_W   = 4;
    localparam int CFG_A_W = 4;
    localparam int WORD_W  = 2 * ELEM_W;

    // product of two Q1.14 values has 28 fraction bits; eight terms fit in 36 bits
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 36;
    localparam int FRAC_DROP = 14;
    localparam int ROUND_HALF = 8192;

    // request commands
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_ROWS_OF_A = 4'd0;
    localparam logic [CFG_A_W-1:0] REG_COLS_OF_A = 4'd1;
    localparam logic [CFG_A_W-1:0] REG_ROWS_OF_B = 4'd2;
    localparam logic [CFG_A_W-1:0] REG_COLS_OF_B = 4'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DIM_ERR = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] real_part;
        logic signed [ELEM_W-1:0] imag_part;
    } cmm_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [OUT_W-1:0] out_real;
        logic signed [OUT_W-1:0] out_imag;
        logic                    last;
        logic                    status;
    } cmm_res_t;

    // control that travels with a pair of store words into the mac
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } cmm_mac_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ERROR
    } cmm_state_t;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    // drop 14 fraction bits, tie toward plus infinity, saturate to 24 bits
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] q;
        logic signed [OUT_W-1:0] r;
        y = x + ACC_W'(ROUND_HALF);
        q = y >>> FRAC_DROP;
        if (q > SAT_HI) begin
            r = SAT_HI[OUT_W-1:0];
        end else if (q < SAT_LO) begin
            r = SAT_LO[OUT_W-1:0];
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/cmm_mac.sv
module cmm_mac
    import cmm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmm_mac_ctl_t             ctl,
    input  logic [WORD_W-1:0]        a_word,
    input  logic [WORD_W-1:0]        b_word,
    output logic                     sum_valid,
    output logic signed [ACC_W-1:0]  sum_real,
    output logic signed [ACC_W-1:0]  sum_imag
);

    logic signed [ELEM_W-1:0] ar, ai, br, bi;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    cmm_mac_ctl_t             ctl_reg;
    logic signed [ACC_W-1:0]  term_real, term_imag;
    logic signed [ACC_W-1:0]  acc_real_reg, acc_real_next;
    logic signed [ACC_W-1:0]  acc_imag_reg, acc_imag_next;
    logic                     sum_valid_reg;

    assign ar = a_word[ELEM_W-1:0];
    assign ai = a_word[WORD_W-1:ELEM_W];
    assign br = b_word[ELEM_W-1:0];
    assign bi = b_word[WORD_W-1:ELEM_W];

    // product stage
    always_ff @(posedge clk)
    begin
        p_rr_reg <= ar * br;
        p_ii_reg <= ai * bi;
        p_ri_reg <= ar * bi;
        p_ir_reg <= ai * br;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl;
            sum_valid_reg <= ctl_reg.valid && ctl_reg.last;
        end
    end

    // accumulate stage, restarted by the first term of each element
    assign term_real = ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
    assign term_imag = ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);

    always_comb
    begin
        acc_real_next = acc_real_reg;
        acc_imag_next = acc_imag_reg;
        if (ctl_reg.valid)
        begin
            if (ctl_reg.first)
            begin
                acc_real_next = term_real;
                acc_imag_next = term_imag;
            end
            else
            begin
                acc_real_next = acc_real_reg + term_real;
                acc_imag_next = acc_imag_reg + term_imag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_real_reg <= acc_real_next;
        acc_imag_reg <= acc_imag_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum_real  = acc_real_reg;
    assign sum_imag  = acc_imag_reg;

endmodule

>>> rtl/complex_matrix_multiply.sv
// complex matrix product C = A x B on Q1.14 complex elements
// request channel (req_valid / req_stall / req_data): a load A or load B request
//   writes one element into the A or B store at row * MAX_DIM + col and gives no
//   result; loads with a position at or past MAX_DIM are dropped
// a start request runs the product over the dimensions in the configuration
//   registers and emits each element of C in row-major order on the result
//   channel (res_valid / res_stall / res_data), last set on the final one
// if cols_of_a differs from rows_of_b a start gives a single result with status 1
// configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are always
//   taken; index above 3 is ignored
// loads are taken back to back
// a start holds req_stall high for the whole run; each C element is built from
//   inner store reads (one read port per store, one term a cycle), which then
//   pass through the read register, the product register, the accumulator and
//   the done flag
// the last result waits in the output register while new requests are taken
// while res_stall is high the finished element holds in the output register and
//   the next element is computed but not issued until the register frees
// reset clears the control and sets every dimension register to 2; store contents
//   are undefined until loaded, and a run may only read entries that were loaded
module complex_matrix_multiply
    import cmm_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cmm_req_t           req_data,
    output logic               res_valid,
    input  logic               res_stall,
    output cmm_res_t           res_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_A_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

    // dimension registers
    logic [DIM_W-1:0] rows_of_a_reg, cols_of_a_reg, rows_of_b_reg, cols_of_b_reg;

    // run control
    cmm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic             acc_done_reg, acc_done_next;
    cmm_mac_ctl_t     rd_ctl_reg, rd_ctl_next;

    // stores and their read registers
    logic [WORD_W-1:0] a_mem [DEPTH];
    logic [WORD_W-1:0] b_mem [DEPTH];
    logic [WORD_W-1:0] a_rd_reg, b_rd_reg;
    logic [AW-1:0]     wr_addr, a_rd_addr, b_rd_addr;

    // output register
    logic     res_valid_reg, res_valid_next;
    cmm_res_t res_data_reg, res_data_next;

    logic             req_take, is_start, in_range, load_a, load_b;
    logic             issue_en, take_sum, emit_err, out_free, dim_mismatch;
    logic [IDX_W-1:0] i_max, j_max, k_max;
    logic             last_elem, last_term;
    logic             sum_valid;
    logic signed [ACC_W-1:0] sum_real, sum_imag;

    // clamp a dimension register to 1..DIM_CAP and return the top index
    function automatic logic [IDX_W-1:0] top_index(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        if (v == '0) begin
            e = DIM_W'(1);
        end else if (int'(v) > DIM_CAP) begin
            e = DIM_W'(DIM_CAP);
        end else begin
            e = v;
        end
        return IDX_W'(e - DIM_W'(1));
    endfunction

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_of_a_reg <= DIM_RESET;
            cols_of_a_reg <= DIM_RESET;
            rows_of_b_reg <= DIM_RESET;
            cols_of_b_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROWS_OF_A: rows_of_a_reg <= cfg_data;
                REG_COLS_OF_A: cols_of_a_reg <= cfg_data;
                REG_ROWS_OF_B: rows_of_b_reg <= cfg_data;
                REG_COLS_OF_B: cols_of_b_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign i_max        = top_index(rows_of_a_reg);
    assign k_max        = top_index(cols_of_a_reg);
    assign j_max        = top_index(cols_of_b_reg);
    // mismatch is judged on the raw register values
    assign dim_mismatch = (cols_of_a_reg != rows_of_b_reg);

    // ---------------------------------------------------------------- request decode
    assign req_take = req_valid && !req_stall;
    assign is_start = (req_data.cmd == CMD_START);
    assign in_range = (int'(req_data.row) < MAX_DIM) && (int'(req_data.col) < MAX_DIM);
    assign load_a   = req_take && (req_data.cmd == CMD_LOAD_A) && in_range;
    assign load_b   = req_take && (req_data.cmd == CMD_LOAD_B) && in_range;

    assign out_free  = !res_valid_reg || !res_stall;
    assign last_term = (k_reg == k_max);
    assign last_elem = (i_reg == i_max) && (j_reg == j_max);

    // ---------------------------------------------------------------- fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && is_start)
                begin
                    state_next = dim_mismatch ? ST_ERROR : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (last_term)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (acc_done_reg && out_free)
                begin
                    state_next = last_elem ? ST_IDLE : ST_ISSUE;
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- fsm outputs
    always_comb
    begin
        req_stall = 1'b1;
        issue_en  = 1'b0;
        take_sum  = 1'b0;
        emit_err  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req_stall = 1'b0;
            ST_ISSUE: issue_en  = 1'b1;
            ST_DRAIN: take_sum  = acc_done_reg && out_free;
            ST_ERROR: emit_err  = out_free;
            default:  req_stall = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------- index counters
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (req_take && is_start)
        begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end
        else if (issue_en)
        begin
            k_next = last_term ? '0 : k_reg + IDX_W'(1);
        end
        else if (take_sum && !last_elem)
        begin
            // walk C in row-major order
            if (j_reg == j_max)
            begin
                j_next = '0;
                i_next = i_reg + IDX_W'(1);
            end
            else
            begin
                j_next = j_reg + IDX_W'(1);
            end
        end
    end

    // a finished sum waits here until the output register takes it
    always_comb
    begin
        acc_done_next = acc_done_reg;
        if (sum_valid)
        begin
            acc_done_next = 1'b1;
        end
        else if (take_sum)
        begin
            acc_done_next = 1'b0;
        end
    end

    always_comb
    begin
        rd_ctl_next.valid = issue_en;
        rd_ctl_next.first = (k_reg == '0);
        rd_ctl_next.last  = last_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            acc_done_reg <= 1'b0;
            rd_ctl_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            acc_done_reg <= acc_done_next;
            rd_ctl_reg   <= rd_ctl_next;
        end
    end

    // ---------------------------------------------------------------- stores
    // loads and runs never overlap: requests are stalled for the whole run
    assign wr_addr   = AW'(int'(req_data.row) * MAX_DIM + int'(req_data.col));
    assign a_rd_addr = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign b_rd_addr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_mem[wr_addr] <= {req_data.imag_part, req_data.real_part};
        end
        a_rd_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_mem[wr_addr] <= {req_data.imag_part, req_data.real_part};
        end
        b_rd_reg <= b_mem[b_rd_addr];
    end

    // ---------------------------------------------------------------- multiply-accumulate
    cmm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rd_ctl_reg),
        .a_word    (a_rd_reg),
        .b_word    (b_rd_reg),
        .sum_valid (sum_valid),
        .sum_real  (sum_real),
        .sum_imag  (sum_imag)
    );

    // ---------------------------------------------------------------- output register
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        if (take_sum)
        begin
            res_valid_next         = 1'b1;
            res_data_next.out_row  = i_reg;
            res_data_next.out_col  = j_reg;
            res_data_next.out_real = round_sat(sum_real);
            res_data_next.out_imag = round_sat(sum_imag);
            res_data_next.last     = last_elem;
            res_data_next.status   = STATUS_OK;
        end
        else if (emit_err)
        begin
            res_valid_next         = 1'b1;
            res_data_next.out_row  = '0;
            res_data_next.out_col  = '0;
            res_data_next.out_real = '0;
            res_data_next.out_imag = '0;
            res_data_next.last     = 1'b1;
            res_data_next.status   = STATUS_DIM_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> dv/complex_matrix_multiply_tb.sv
`timescale 1ns / 100ps

// self-checking bench for the complex matrix multiplier
// an in-bench predictor keeps its own copy of the A and B stores and of the
// dimension registers, and queues the product elements each start request
// should produce; a monitor pops them in order as results are accepted
module complex_matrix_multiply_tb;
    import cmm_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int CLK_HALF = 6;

    // cycles to let the mac pipeline settle after the last result
    localparam int SETTLE_CYCLES = 16;

    // cycles without any accepted request, result or register write
    localparam int STUCK_LIMIT = 3000;

    localparam int RAND_ITEMS = 64;

    // the one command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

    // 0.5 in Q1.14, used to land products exactly on a rounding tie
    localparam logic signed [ELEM_W-1:0] ELEM_HALF = 16'sd8192;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    cmm_req_t           req_data;
    logic               res_valid;
    logic               res_stall = 1'b0;
    cmm_res_t           res_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_A_W-1:0] cfg_index;
    logic [DIM_W-1:0]   cfg_data;

    // predictor state: element stores, which entries hold data, dimensions
    logic signed [ELEM_W-1:0] a_re [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] a_im [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_re [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_im [MAX_DIM*MAX_DIM];
    bit                       a_loaded [MAX_DIM*MAX_DIM];
    bit                       b_loaded [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]         dim_regs [4];

    // product elements still owed by the block, oldest first
    cmm_res_t pending_elems [$];

    int items_sent = 0;
    int fail_count = 0;
    int stuck_cycles = 0;

    // idle rates in percent for the request sender and the result receiver
    int send_idle_pct = 34;
    int recv_stall_pct = 80;

    complex_matrix_multiply #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // result side back-pressure, changed only on the falling edge
    always @(negedge clk)
        res_stall = ($urandom_range(99) < recv_stall_pct);

    // register value as the block uses it for a run
    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_CAP)
            return DIM_CAP;
        return int'(v);
    endfunction

    // 28 fraction bits down to 14, tie toward plus infinity, then clip to 24 bits
    function automatic logic signed [OUT_W-1:0] scale_to_out(input longint acc);
        longint q;
        q = (acc + 64'sd8192) >>> 14;
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        if (q < -64'sd8388608)
            q = -64'sd8388608;
        return q[OUT_W-1:0];
    endfunction

    // apply one accepted request to the predictor and queue what it causes
    function automatic void predict_request(input cmm_req_t r);
        int       addr;
        int       ra;
        int       inner;
        int       cb;
        longint   acc_re;
        longint   acc_im;
        longint   ar;
        longint   ai;
        longint   br;
        longint   bi;
        cmm_res_t elem;
        addr = int'(r.row) * MAX_DIM + int'(r.col);
        case (r.cmd)
            CMD_LOAD_A:
            begin
                a_re[addr] = r.real_part;
                a_im[addr] = r.imag_part;
                a_loaded[addr] = 1'b1;
            end
            CMD_LOAD_B:
            begin
                b_re[addr] = r.real_part;
                b_im[addr] = r.imag_part;
                b_loaded[addr] = 1'b1;
            end
            CMD_START:
            begin
                // mismatch is judged on the raw register values
                if (dim_regs[REG_COLS_OF_A] != dim_regs[REG_ROWS_OF_B])
                begin
                    elem = '0;
                    elem.last = 1'b1;
                    elem.status = STATUS_DIM_ERR;
                    pending_elems.push_back(elem);
                end
                else
                begin
                    ra = clamp_dim(dim_regs[REG_ROWS_OF_A]);
                    inner = clamp_dim(dim_regs[REG_COLS_OF_A]);
                    cb = clamp_dim(dim_regs[REG_COLS_OF_B]);
                    for (int i = 0; i < ra; i++)
                    begin
                        for (int j = 0; j < cb; j++)
                        begin
                            acc_re = 0;
                            acc_im = 0;
                            for (int k = 0; k < inner; k++)
                            begin
                                ar = a_re[i*MAX_DIM + k];
                                ai = a_im[i*MAX_DIM + k];
                                br = b_re[k*MAX_DIM + j];
                                bi = b_im[k*MAX_DIM + j];
                                acc_re += ar * br - ai * bi;
                                acc_im += ar * bi + ai * br;
                            end
                            elem.out_row = IDX_W'(i);
                            elem.out_col = IDX_W'(j);
                            elem.out_real = scale_to_out(acc_re);
                            elem.out_imag = scale_to_out(acc_im);
                            elem.last = (i == ra - 1) && (j == cb - 1);
                            elem.status = STATUS_OK;
                            pending_elems.push_back(elem);
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endfunction

    function automatic cmm_req_t make_req(
        input logic [CMD_W-1:0]         cmd,
        input logic [IDX_W-1:0]         row,
        input logic [IDX_W-1:0]         col,
        input logic signed [ELEM_W-1:0] re,
        input logic signed [ELEM_W-1:0] im
    );
        cmm_req_t r;
        r.cmd = cmd;
        r.row = row;
        r.col = col;
        r.real_part = re;
        r.imag_part = im;
        return r;
    endfunction

    // element part, leaning on the two extremes
    function automatic logic signed [ELEM_W-1:0] rand_part();
        case ($urandom_range(7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic void compare_field(
        input string               name,
        input logic signed [OUT_W:0] want,
        input logic signed [OUT_W:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result monitor: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        cmm_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_elems.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d status %0d",
                       res_data.out_row, res_data.out_col, res_data.status);
                fail_count++;
            end
            else
            begin
                want = pending_elems.pop_front();
                compare_field("out_row", want.out_row, res_data.out_row);
                compare_field("out_col", want.out_col, res_data.out_col);
                compare_field("out_real", want.out_real, res_data.out_real);
                compare_field("out_imag", want.out_imag, res_data.out_imag);
                compare_field("last", want.last, res_data.last);
                compare_field("status", want.status, res_data.status);
            end
        end
    end

    // watchdog on progress of any of the three channels
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one request; entered and left at a falling edge, valid left high so the
    // next request can follow back to back
    task automatic send_request(input cmm_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_data = r;
        do
            @(posedge clk);
        while (req_stall);
        predict_request(r);
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait for every owed result, then let the mac go quiet
    task automatic wait_for_drain();
        req_valid = 1'b0;
        while (pending_elems.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // all four dimension registers plus one write to an unused index
    task automatic write_dims(
        input logic [DIM_W-1:0] ra,
        input logic [DIM_W-1:0] ca,
        input logic [DIM_W-1:0] rb,
        input logic [DIM_W-1:0] cb
    );
        logic [CFG_A_W-1:0] idx [5];
        logic [DIM_W-1:0]   val [5];
        idx = '{REG_ROWS_OF_A, REG_COLS_OF_A, REG_ROWS_OF_B, REG_COLS_OF_B,
                CFG_A_W'($urandom_range(15, 4))};
        val = '{ra, ca, rb, cb, DIM_W'($urandom)};
        wait_for_drain();
        for (int n = 0; n < 5; n++)
        begin
            cfg_valid = 1'b1;
            cfg_index = idx[n];
            cfg_data = val[n];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (idx[n] <= REG_COLS_OF_B)
                dim_regs[idx[n]] = val[n];
            @(negedge clk);
        end
        cfg_valid = 1'b0;
    endtask

    // load whatever entries the current dimensions read and are still empty,
    // then issue the start request
    task automatic run_multiply();
        int ra;
        int inner;
        int cb;
        ra = clamp_dim(dim_regs[REG_ROWS_OF_A]);
        inner = clamp_dim(dim_regs[REG_COLS_OF_A]);
        cb = clamp_dim(dim_regs[REG_COLS_OF_B]);
        if (dim_regs[REG_COLS_OF_A] == dim_regs[REG_ROWS_OF_B])
        begin
            for (int i = 0; i < ra; i++)
                for (int k = 0; k < inner; k++)
                    if (!a_loaded[i*MAX_DIM + k])
                        send_request(make_req(CMD_LOAD_A, IDX_W'(i), IDX_W'(k),
                                              rand_part(), rand_part()));
            for (int k = 0; k < inner; k++)
                for (int j = 0; j < cb; j++)
                    if (!b_loaded[k*MAX_DIM + j])
                        send_request(make_req(CMD_LOAD_B, IDX_W'(k), IDX_W'(j),
                                              rand_part(), rand_part()));
        end
        // position and value are don't-care on a start, so randomize them
        send_request(make_req(CMD_START, IDX_W'($urandom), IDX_W'($urandom),
                              rand_part(), rand_part()));
    endtask

    // reset dimensions (2x2 times 2x2): extreme parts, ties on the negative side
    task automatic test_reset_dims();
        send_request(make_req(CMD_LOAD_A, 3'd0, 3'd0, ELEM_MIN, ELEM_MIN));
        send_request(make_req(CMD_LOAD_A, 3'd0, 3'd1, ELEM_MAX, ELEM_MAX));
        send_request(make_req(CMD_LOAD_A, 3'd1, 3'd0, 16'sd1, 16'sd0));
        send_request(make_req(CMD_LOAD_A, 3'd1, 3'd1, -16'sd1, 16'sd0));
        send_request(make_req(CMD_LOAD_B, 3'd0, 3'd0, ELEM_MIN, ELEM_MAX));
        send_request(make_req(CMD_LOAD_B, 3'd0, 3'd1, ELEM_HALF, 16'sd0));
        send_request(make_req(CMD_LOAD_B, 3'd1, 3'd0, ELEM_MAX, ELEM_MIN));
        send_request(make_req(CMD_LOAD_B, 3'd1, 3'd1, ELEM_HALF, 16'sd0));
        // far corner of the stores, not read by this run
        send_request(make_req(CMD_LOAD_A, 3'd7, 3'd7, ELEM_MAX, ELEM_MIN));
        send_request(make_req(CMD_LOAD_B, 3'd7, 3'd7, ELEM_MIN, ELEM_MAX));
        // unused command must pass without a result
        send_request(make_req(CMD_UNUSED, 3'd5, 3'd2, rand_part(), rand_part()));
        run_multiply();
    endtask

    // inner dimensions disagree: each start gives one error result, nothing read
    task automatic test_dim_mismatch();
        write_dims(4'd2, 4'd3, 4'd2, 4'd2);
        run_multiply();
        // both clip to 8 but the raw values still differ
        write_dims(4'd8, 4'd8, 4'd9, 4'd8);
        run_multiply();
    endtask

    // register values outside 1..8 are clipped for the run
    task automatic test_dim_clamp();
        write_dims(4'd0, 4'd0, 4'd0, 4'd0);
        run_multiply();
        write_dims(4'd1, 4'd1, 4'd1, 4'd15);
        run_multiply();
        write_dims(4'd15, 4'd1, 4'd1, 4'd1);
        run_multiply();
    endtask

    // longest runs: 8x1 times 1x8 gives all 64 results, 1x8 times 8x1 the
    // longest sum
    task automatic test_largest();
        write_dims(4'd15, 4'd1, 4'd1, 4'd15);
        run_multiply();
        write_dims(4'd1, 4'd15, 4'd15, 4'd1);
        run_multiply();
    endtask

    // random load sequences followed by starts, mostly small matrices
    task automatic test_random();
        int               first_item;
        int               progress;
        int               sel;
        int               nloads;
        logic [CMD_W-1:0] cmd;
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] ca;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] cb;
        first_item = items_sent;
        while (items_sent - first_item < RAND_ITEMS)
        begin
            // idle profile: slow receiver, then slow sender, then full rate
            progress = items_sent - first_item;
            if (progress < RAND_ITEMS / 3)
            begin
                send_idle_pct = 34;
                recv_stall_pct = 80;
            end
            else if (progress < 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 80;
                recv_stall_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end

            if ($urandom_range(1) == 0)
            begin
                sel = $urandom_range(99);
                ra = DIM_W'($urandom_range(1, 3));
                ca = DIM_W'($urandom_range(1, 3));
                rb = ca;
                cb = DIM_W'($urandom_range(1, 3));
                if (sel >= 92)
                begin
                    // long outer dimensions, up to 8
                    ra = DIM_W'($urandom_range(1, 8));
                    cb = DIM_W'($urandom_range(1, 8));
                end
                else if (sel >= 80)
                begin
                    // raw outer values, clipped by the block; zero or small inner
                    ra = DIM_W'($urandom);
                    ca = DIM_W'($urandom_range(0, 3));
                    rb = ca;
                    cb = DIM_W'($urandom);
                end
                else if (sel >= 70)
                begin
                    // broken setup: inner dimensions disagree
                    do
                        rb = DIM_W'($urandom);
                    while (rb == ca);
                end
                write_dims(ra, ca, rb, cb);
            end

            nloads = $urandom_range(0, 6);
            repeat (nloads)
            begin
                cmd = ($urandom_range(9) == 0) ? CMD_UNUSED
                    : ($urandom_range(1) == 0) ? CMD_LOAD_A : CMD_LOAD_B;
                send_request(make_req(cmd, IDX_W'($urandom), IDX_W'($urandom),
                                      rand_part(), rand_part()));
            end
            run_multiply();
            // now and then a second start straight after the first
            if ($urandom_range(3) == 0)
                run_multiply();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int n = 0; n < 4; n++)
            dim_regs[n] = DIM_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_dims();
        test_dim_mismatch();
        test_dim_clamp();
        test_largest();
        test_random();

        wait_for_drain();
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/cmm_pkg.sv
rtl/cmm_mac.sv
rtl/complex_matrix_multiply.sv
dv/complex_matrix_multiply_tb.sv
